// ===== sv/lrt_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and helpers for the longest prefix match route table.
// No dependencies; used by lrt_ctrl, lrt_datapath and lpm_route_table.
package lrt_pkg;

    // Operation codes carried in the input tuser
    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_ROUTE = 1'b1;

    // Result status codes carried in the output tuser
    localparam logic [2:0] ST_ADDED     = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_FORWARDED = 3'd2;
    localparam logic [2:0] ST_EXPIRED   = 3'd3;
    localparam logic [2:0] ST_NO_ROUTE  = 3'd4;

    localparam logic [5:0] MAX_LEN = 6'd32;

    // One stored route
    typedef struct packed {
        logic [31:0] prefix;
        logic [5:0]  length;
        logic        gw_flag;
        logic [31:0] gateway;
        logic [7:0]  port;
    } t_route_entry;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_SCAN,
        S_LAST,
        S_DONE
    } t_lrt_state;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic scan_clear;
        logic rd_issue;
        logic finish;
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic expired;
        logic count_zero;
        logic ptr_last;
        logic out_free;
    } t_dp_status;

    // Saturate a prefix length at 32
    function automatic logic [5:0] sat_len(input logic [5:0] len);
        return (len > MAX_LEN) ? MAX_LEN : len;
    endfunction

    // Mask with the top len bits set; len is already saturated
    function automatic logic [31:0] len_mask(input logic [5:0] len);
        return ~(32'hFFFF_FFFF >> len);
    endfunction

endpackage

// ===== sv/lrt_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer for the route table: accept, scan the table, deliver the result.
// Depends on lrt_pkg for the state type and the command/status structs.
module lrt_ctrl
    import lrt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_lrt_state r_state;
    t_lrt_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        s_axis_tready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
                o_cmd.load    = s_axis_tvalid;
                if (s_axis_tvalid) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                o_cmd.scan_clear = 1'b1;
                // skip the walk for an expired datagram or an empty table
                if (i_status.expired || i_status.count_zero) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.rd_issue = 1'b1;
                if (i_status.ptr_last) begin
                    n_state = S_LAST;
                end
            end
            S_LAST: begin
                // compare of the final entry happens here
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (r_state == S_START))
        else $error("accepted item did not start the sequence");

    a_scan_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> !i_status.count_zero)
        else $error("table walk on an empty table");

endmodule

// ===== sv/lrt_datapath.sv =====
`timescale 1ns / 1ps
// Datapath of the route table: route memory, fill count, match logic, result register.
// Depends on lrt_pkg for entry layout, codes and the command/status structs.
module lrt_datapath
    import lrt_pkg::*;
#(
    parameter int ROUTE_ENTRIES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    output t_dp_status  o_status,
    input  logic        i_operation,
    input  logic [31:0] i_address,
    input  logic [5:0]  i_prefix_len,
    input  logic        i_has_next_hop,
    input  logic [31:0] i_next_hop_address,
    input  logic [7:0]  i_route_port,
    input  logic [7:0]  i_ttl,
    input  logic        i_out_ready,
    output logic        o_out_valid,
    output logic [2:0]  o_status_code,
    output logic [7:0]  o_egress_port,
    output logic [31:0] o_forward_address,
    output logic [7:0]  o_new_ttl
);

    localparam int IDX_W = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(ROUTE_ENTRIES + 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(ROUTE_ENTRIES);

    // Route memory; entries 0 .. count-1 are valid
    t_route_entry r_mem [ROUTE_ENTRIES];

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_ptr;
    logic             r_rd_vld;
    t_route_entry     r_rd_data;
    logic [IDX_W-1:0] r_rd_idx;

    // Latched item
    logic        r_op;
    logic [31:0] r_addr;
    logic [5:0]  r_len;
    logic [31:0] r_pfx;
    logic        r_gw_flag;
    logic [31:0] r_gw;
    logic [7:0]  r_port;
    logic [7:0]  r_ttl;

    // Best match so far
    logic             r_found;
    logic [5:0]       r_best_len;
    logic [IDX_W-1:0] r_best_idx;
    logic [7:0]       r_best_port;
    logic             r_best_gw_flag;
    logic [31:0]      r_best_gw;

    // Result register
    logic        r_out_valid;
    logic [2:0]  r_out_status;
    logic [7:0]  r_out_port;
    logic [31:0] r_out_addr;
    logic [7:0]  r_out_ttl;

    logic [5:0]   in_len;
    logic         full;
    logic         expired;
    logic         take;
    logic         do_write;
    logic [IDX_W-1:0] wr_idx;
    t_route_entry wr_data;
    logic [2:0]   res_status;

    assign in_len  = sat_len(i_prefix_len);
    assign full    = (r_count == FULL_COUNT);
    assign expired = (r_op == OP_ROUTE) && (r_ttl <= 8'd1);

    // Pick the entry just read: longest match for a datagram, equal entry for an add
    always_comb begin
        take = 1'b0;
        if (r_rd_vld) begin
            if (r_op == OP_ROUTE) begin
                take = ((r_addr & len_mask(r_rd_data.length)) == r_rd_data.prefix)
                       && (!r_found || (r_rd_data.length > r_best_len));
            end else begin
                take = !r_found && (r_rd_data.length == r_len)
                       && (r_rd_data.prefix == r_pfx);
            end
        end
    end

    // Overwrite the equal entry, else append when there is room
    assign do_write = i_cmd.finish && (r_op == OP_ADD) && (r_found || !full);
    assign wr_idx   = r_found ? r_best_idx : r_count[IDX_W-1:0];
    always_comb begin
        wr_data.prefix  = r_pfx;
        wr_data.length  = r_len;
        wr_data.gw_flag = r_gw_flag;
        wr_data.gateway = r_gw;
        wr_data.port    = r_port;
    end

    always_comb begin
        if (r_op == OP_ADD) begin
            res_status = (r_found || !full) ? ST_ADDED : ST_FULL;
        end else if (expired) begin
            res_status = ST_EXPIRED;
        end else if (r_found) begin
            res_status = ST_FORWARDED;
        end else begin
            res_status = ST_NO_ROUTE;
        end
    end

    // Memory write and registered read
    always_ff @(posedge i_clk) begin
        if (do_write) begin
            r_mem[wr_idx] <= wr_data;
        end
        if (i_cmd.rd_issue) begin
            r_rd_data <= r_mem[r_ptr[IDX_W-1:0]];
        end
    end

    // Latch the item and track the best entry
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op      <= i_operation;
            r_addr    <= i_address;
            r_len     <= in_len;
            r_pfx     <= i_address & len_mask(in_len);
            r_gw_flag <= i_has_next_hop;
            r_gw      <= i_next_hop_address;
            r_port    <= i_route_port;
            r_ttl     <= i_ttl;
        end
        r_rd_idx <= r_ptr[IDX_W-1:0];
        if (take) begin
            r_best_len     <= r_rd_data.length;
            r_best_idx     <= r_rd_idx;
            r_best_port    <= r_rd_data.port;
            r_best_gw_flag <= r_rd_data.gw_flag;
            r_best_gw      <= r_rd_data.gateway;
        end
        if (i_cmd.finish) begin
            r_out_status <= res_status;
            r_out_port   <= (res_status == ST_FORWARDED) ? r_best_port : 8'd0;
            r_out_addr   <= (res_status == ST_FORWARDED)
                            ? (r_best_gw_flag ? r_best_gw : r_addr) : 32'd0;
            r_out_ttl    <= (res_status == ST_FORWARDED) ? (r_ttl - 8'd1) : 8'd0;
        end
    end

    // Control registers: fill count, walk pointer, match flag, result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_ptr       <= '0;
            r_rd_vld    <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.rd_issue;
            if (i_cmd.scan_clear) begin
                r_ptr   <= '0;
                r_found <= 1'b0;
            end else begin
                if (i_cmd.rd_issue) begin
                    r_ptr <= r_ptr + 1'b1;
                end
                if (take) begin
                    r_found <= 1'b1;
                end
            end
            if (do_write && !r_found) begin
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.expired    = expired;
    assign o_status.count_zero = (r_count == '0);
    assign o_status.ptr_last   = ((r_ptr + 1'b1) == r_count);
    assign o_status.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid       = r_out_valid;
    assign o_status_code     = r_out_status;
    assign o_egress_port     = r_out_port;
    assign o_forward_address = r_out_addr;
    assign o_new_ttl         = r_out_ttl;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_COUNT)
        else $error("route count beyond table size");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == $past(r_count)) || (r_count == $past(r_count) + 1'b1))
        else $error("route count moved by more than one");

    a_read_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd_issue |-> (r_ptr < r_count))
        else $error("table read beyond the filled entries");

endmodule

// ===== sv/lpm_route_table.sv =====
`timescale 1ns / 1ps
// IPv4 longest prefix match route table: top level with stream ports.
// Depends on lrt_pkg, lrt_ctrl and lrt_datapath.
// An accepted item passes through S_START, S_SCAN over the N stored routes,
// S_LAST and S_DONE (straight from S_START to S_DONE for an expired datagram
// or an empty table); the walk reads one table entry per cycle through the
// single memory read port. A new item is accepted only in S_IDLE, after S_DONE.
// Reset clears the route count and the result valid flag; no clearing pass.
module lpm_route_table
    import lrt_pkg::*;
#(
    parameter int ROUTE_ENTRIES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [31:0] address, [37:32] prefix_len, [38] has_next_hop,
    // [70:39] next_hop_address, [78:71] route_port, [86:79] ttl, [87] zero
    input  logic [87:0] s_axis_tdata,
    // [0] operation
    input  logic [0:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] egress_port, [39:8] forward_address, [47:40] new_ttl
    output logic [47:0] m_axis_tdata,
    // [2:0] status
    output logic [2:0]  m_axis_tuser
);

    t_dp_cmd    cmd;
    t_dp_status status;

    lrt_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .i_status      (status),
        .o_cmd         (cmd)
    );

    lrt_datapath #(
        .ROUTE_ENTRIES (ROUTE_ENTRIES)
    ) u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_status           (status),
        .i_operation        (s_axis_tuser[0]),
        .i_address          (s_axis_tdata[31:0]),
        .i_prefix_len       (s_axis_tdata[37:32]),
        .i_has_next_hop     (s_axis_tdata[38]),
        .i_next_hop_address (s_axis_tdata[70:39]),
        .i_route_port       (s_axis_tdata[78:71]),
        .i_ttl              (s_axis_tdata[86:79]),
        .i_out_ready        (m_axis_tready),
        .o_out_valid        (m_axis_tvalid),
        .o_status_code      (m_axis_tuser),
        .o_egress_port      (m_axis_tdata[7:0]),
        .o_forward_address  (m_axis_tdata[39:8]),
        .o_new_ttl          (m_axis_tdata[47:40])
    );

endmodule

// ===== bench/lrt_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for lpm_route_table: watches both stream channels, keeps its own
// copy of the route table to predict each result and compares field by field.
// Depends on lrt_pkg for the operation and status codes.
module lrt_checker
    import lrt_pkg::*;
#(
    parameter int ROUTE_ENTRIES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    // [31:0] address, [37:32] prefix_len, [38] has_next_hop,
    // [70:39] next_hop_address, [78:71] route_port, [86:79] ttl, [87] zero
    input  logic [87:0] i_s_tdata,
    // [0] operation
    input  logic [0:0]  i_s_tuser,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    // [7:0] egress_port, [39:8] forward_address, [47:40] new_ttl
    input  logic [47:0] i_m_tdata,
    // [2:0] status
    input  logic [2:0]  i_m_tuser,
    output int          o_mismatches,
    output int          o_outstanding
);

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  egress_port;
        logic [31:0] forward_address;
        logic [7:0]  new_ttl;
    } t_lrt_result;

    // Shadow route table; entries below rt_count are the valid ones
    logic [31:0] rt_prefix  [ROUTE_ENTRIES];
    logic [5:0]  rt_len     [ROUTE_ENTRIES];
    logic        rt_gw_flag [ROUTE_ENTRIES];
    logic [31:0] rt_gateway [ROUTE_ENTRIES];
    logic [7:0]  rt_port    [ROUTE_ENTRIES];
    int          rt_count;

    t_lrt_result route_results_due[$];
    t_lrt_result due;
    int          results_checked;

    // Network mask with the top len bits set, len already at most 32
    function automatic logic [31:0] net_mask(input logic [5:0] len);
        return (len == 6'd0) ? 32'd0 : (32'hFFFF_FFFF << (6'd32 - len));
    endfunction

    // Apply one request to the shadow table and work out the result it gives
    function automatic t_lrt_result next_route_result(input logic [87:0] data,
                                                      input logic op);
        t_lrt_result res;
        logic [31:0] addr;
        logic [5:0]  len;
        logic        gw_flag;
        logic [31:0] gw;
        logic [7:0]  port;
        logic [7:0]  ttl;
        bit          hit;
        int          best;
        addr    = data[31:0];
        len     = data[37:32];
        gw_flag = data[38];
        gw      = data[70:39];
        port    = data[78:71];
        ttl     = data[86:79];
        res     = '0;
        hit     = 1'b0;
        best    = 0;
        if (op == OP_ADD) begin
            // Over-long prefixes count as host routes; host bits are dropped
            if (len > 6'd32) begin
                len = 6'd32;
            end
            addr = addr & net_mask(len);
            res.status = ST_ADDED;
            for (int i = 0; i < rt_count; i++) begin
                if (!hit && rt_len[i] == len && rt_prefix[i] == addr) begin
                    rt_gw_flag[i] = gw_flag;
                    rt_gateway[i] = gw;
                    rt_port[i]    = port;
                    hit = 1'b1;
                end
            end
            if (!hit) begin
                if (rt_count >= ROUTE_ENTRIES) begin
                    res.status = ST_FULL;
                end else begin
                    rt_prefix[rt_count]  = addr;
                    rt_len[rt_count]     = len;
                    rt_gw_flag[rt_count] = gw_flag;
                    rt_gateway[rt_count] = gw;
                    rt_port[rt_count]    = port;
                    rt_count++;
                end
            end
        end else if (ttl <= 8'd1) begin
            res.status = ST_EXPIRED;
        end else begin
            // Keep the longest matching prefix; the first wins on equal length
            for (int i = 0; i < rt_count; i++) begin
                if ((addr & net_mask(rt_len[i])) == rt_prefix[i]) begin
                    if (!hit || rt_len[i] > rt_len[best]) begin
                        hit  = 1'b1;
                        best = i;
                    end
                end
            end
            if (hit) begin
                res.status          = ST_FORWARDED;
                res.egress_port     = rt_port[best];
                res.forward_address = rt_gw_flag[best] ? rt_gateway[best] : addr;
                res.new_ttl         = ttl - 8'd1;
            end else begin
                res.status = ST_NO_ROUTE;
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        $display("[%0t] result %0d: %s is %h, expected %h",
                 $time, results_checked, field, got, exp_val);
        o_mismatches++;
    endtask

    // Check results before queueing new requests so that a result never
    // meets the expectation of an item taken on the same edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rt_count        = 0;
            results_checked = 0;
            o_mismatches    = 0;
            route_results_due.delete();
            o_outstanding <= 0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (route_results_due.size() == 0) begin
                    report_mismatch("status of unrequested item", 32'(i_m_tuser),
                                    32'd0);
                end else begin
                    due = route_results_due.pop_front();
                    if (i_m_tuser != due.status) begin
                        report_mismatch("status", 32'(i_m_tuser), 32'(due.status));
                    end
                    if (i_m_tdata[7:0] != due.egress_port) begin
                        report_mismatch("egress_port", 32'(i_m_tdata[7:0]),
                                        32'(due.egress_port));
                    end
                    if (i_m_tdata[39:8] != due.forward_address) begin
                        report_mismatch("forward_address", i_m_tdata[39:8],
                                        due.forward_address);
                    end
                    if (i_m_tdata[47:40] != due.new_ttl) begin
                        report_mismatch("new_ttl", 32'(i_m_tdata[47:40]),
                                        32'(due.new_ttl));
                    end
                end
                results_checked++;
            end
            if (i_s_tvalid && i_s_tready) begin
                route_results_due.push_back(next_route_result(i_s_tdata, i_s_tuser[0]));
            end
            o_outstanding <= route_results_due.size();
        end
    end

endmodule

// ===== bench/tb_lpm_route_table.sv =====
`timescale 1ns / 1ps
// Testbench top for lpm_route_table: clock, reset, route and datagram items,
// random back-pressure, watchdog and verdict.
// Depends on lrt_pkg, lpm_route_table and lrt_checker.
module tb_lpm_route_table;
    import lrt_pkg::*;

    localparam int ROUTE_ENTRIES  = 64;
    localparam int RANDOM_ITEMS   = 1900;
    localparam int DEFAULT_AT     = 1200;
    localparam int POOL_CAP       = 54;
    localparam int STEADY_FROM    = 900;
    localparam int STEADY_TO      = 1150;
    localparam int HOLD_AFTER     = 300;
    localparam int HOLD_CYCLES    = 600;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct packed {
        logic        op;
        logic [31:0] addr;
        logic [5:0]  plen;
        logic        gw_flag;
        logic [31:0] gw;
        logic [7:0]  port;
        logic [7:0]  ttl;
    } t_route_req;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [87:0] s_axis_tdata;
    logic [0:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;

    int          mismatches;
    int          outstanding;
    int          items_sent;
    int          results_taken;
    int          idle_cycles;

    // Prefixes known to be in the table, used to aim datagrams and overwrites
    logic [31:0] known_pfx[$];
    logic [5:0]  known_len[$];

    lpm_route_table #(
        .ROUTE_ENTRIES (ROUTE_ENTRIES)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    lrt_checker #(
        .ROUTE_ENTRIES (ROUTE_ENTRIES)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (s_axis_tvalid),
        .i_s_tready    (s_axis_tready),
        .i_s_tdata     (s_axis_tdata),
        .i_s_tuser     (s_axis_tuser),
        .i_m_tvalid    (m_axis_tvalid),
        .i_m_tready    (m_axis_tready),
        .i_m_tdata     (m_axis_tdata),
        .i_m_tuser     (m_axis_tuser),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Host part of an address for a given prefix length
    function automatic logic [31:0] host_bits(input logic [5:0] len);
        return (len >= 6'd32) ? 32'd0 : (32'hFFFF_FFFF >> len);
    endfunction

    // Offer one item, with random gaps outside the steady stretch
    task automatic offer(input t_route_req req);
        while (!(items_sent >= STEADY_FROM && items_sent < STEADY_TO) &&
               $urandom_range(0, 99) < 29) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req.op;
        s_axis_tdata  <= {1'b0, req.ttl, req.port, req.gw, req.gw_flag, req.plen, req.addr};
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
    endtask

    task automatic put_route(input logic [31:0] addr, input logic [5:0] len,
                             input logic gw_flag, input logic [31:0] gw,
                             input logic [7:0] port);
        t_route_req  req;
        logic [5:0]  slen;
        logic [31:0] pfx;
        bit          seen;
        req  = {OP_ADD, addr, len, gw_flag, gw, port, 8'($urandom)};
        slen = (len > 6'd32) ? 6'd32 : len;
        pfx  = addr & ~host_bits(slen);
        seen = 1'b0;
        offer(req);
        foreach (known_pfx[i]) begin
            if (known_pfx[i] == pfx && known_len[i] == slen) begin
                seen = 1'b1;
            end
        end
        if (!seen && known_pfx.size() < ROUTE_ENTRIES) begin
            known_pfx.push_back(pfx);
            known_len.push_back(slen);
        end
    endtask

    // Datagram item; the fields an add would use carry random junk
    task automatic route_to(input logic [31:0] addr, input logic [7:0] ttl);
        t_route_req req;
        req = {OP_ROUTE, addr, 6'($urandom), 1'($urandom), 32'($urandom),
               8'($urandom), ttl};
        offer(req);
    endtask

    // Receiver: random stalls, a steady stretch and one long hold-off
    initial begin
        bit held;
        held = 1'b0;
        m_axis_tready <= 1'b0;
        results_taken = 0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) begin
                results_taken++;
            end
            if (!held && results_taken >= HOLD_AFTER) begin
                held = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                m_axis_tready <= (results_taken >= STEADY_FROM &&
                                  results_taken < STEADY_TO) ||
                                 ($urandom_range(0, 99) >= 29);
            end
        end
    end

    // Abort when nothing moves on either channel for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int          pick;
        int          k;
        logic [31:0] pfx;
        logic [5:0]  len;
        logic [5:0]  new_len;
        logic [7:0]  ttl;
        items_sent = 0;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty table, expiry, host bits, saturation, overwrite
        route_to(32'h0A00_0001, 8'd64);
        route_to(32'h0A00_0001, 8'd0);
        route_to(32'h0A00_0001, 8'd1);
        put_route(32'h0A00_0000, 6'd8, 1'b1, 32'hC0A8_0001, 8'd1);
        put_route(32'h0A01_0203, 6'd16, 1'b0, 32'hDEAD_BEEF, 8'd2);
        put_route(32'h0A01_0200, 6'd24, 1'b1, 32'hC0A8_0002, 8'd3);
        put_route(32'hFFFF_FFFF, 6'd32, 1'b0, 32'h0000_0000, 8'hFF);
        put_route(32'hC633_6401, 6'd63, 1'b1, 32'hFFFF_FFFF, 8'd4);
        route_to(32'h0A01_024D, 8'd255);
        route_to(32'h0A01_0909, 8'd2);
        route_to(32'h0AC8_0001, 8'd100);
        route_to(32'h0B00_0001, 8'd100);
        route_to(32'hFFFF_FFFF, 8'd7);
        route_to(32'hFFFF_FFFE, 8'd7);
        put_route(32'h0A01_02FF, 6'd24, 1'b0, 32'h1234_5678, 8'd9);
        route_to(32'h0A01_0205, 8'd3);
        route_to(32'hC633_6401, 8'd9);
        route_to(32'hC633_6400, 8'd9);
        put_route(32'h0000_0000, 6'd32, 1'b1, 32'hFFFF_FFFF, 8'd0);
        route_to(32'h0000_0000, 8'd128);
        put_route(32'h8000_0000, 6'd1, 1'b1, 32'hFFFF_FFFF, 8'd200);
        route_to(32'h8123_4567, 8'd2);
        route_to(32'h0A01_0201, 8'd1);

        // Random: the table stays below full, so misses remain possible,
        // until the default route goes in; after that it fills up
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            k    = $urandom_range(0, known_pfx.size() - 1);
            pfx  = known_pfx[k] | ($urandom & host_bits(known_len[k]));
            len  = known_len[k];
            if (n == DEFAULT_AT) begin
                put_route($urandom, 6'd0, 1'($urandom), $urandom, 8'($urandom));
            end else if (pick < 30) begin
                if ($urandom_range(0, 99) < 35 ||
                    (n < DEFAULT_AT && known_pfx.size() >= POOL_CAP)) begin
                    // Rewrite a known route, host bits and over-long length too
                    if (len == 6'd32 && $urandom_range(0, 1)) begin
                        len = 6'($urandom_range(32, 63));
                    end
                    put_route(pfx, len, 1'($urandom), $urandom, 8'($urandom));
                end else if ($urandom_range(0, 1) && len < 6'd32) begin
                    // Nest a longer prefix under a known one
                    new_len = 6'($urandom_range(len + 1, 32));
                    put_route(pfx, new_len, 1'($urandom), $urandom, 8'($urandom));
                end else begin
                    pick = $urandom_range(0, 99);
                    if (pick < 10) begin
                        new_len = 6'($urandom_range(33, 63));
                    end else if (pick < 13 && n > DEFAULT_AT) begin
                        new_len = 6'd0;
                    end else begin
                        new_len = 6'($urandom_range(1, 32));
                    end
                    put_route($urandom, new_len, 1'($urandom), $urandom,
                              8'($urandom));
                end
            end else begin
                ttl = ($urandom_range(0, 99) < 6) ? 8'($urandom_range(0, 1))
                                                  : 8'($urandom);
                if ($urandom_range(0, 99) < 65) begin
                    route_to(pfx, ttl);
                end else begin
                    route_to($urandom, ttl);
                end
            end
        end
        s_axis_tvalid <= 1'b0;

        // Drain, then allow one full table walk for anything stray
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (ROUTE_ENTRIES + 8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
